// ===== sv/note_tone_sequencer_defines.svh =====
// assertion macros used by the note tone sequencer control module
`ifndef NOTE_TONE_SEQUENCER_DEFINES_SVH
`define NOTE_TONE_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define NTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/nts_pkg.sv =====
// shared constants and control types for the note tone sequencer
package nts_pkg;

  localparam int NoteEntries = 8;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NOTE = 2'd1;
  localparam logic [1:0] CMD_BEEP = 2'd2;

  localparam logic [2:0] REG_NOTE_NAMES       = 3'd0;
  localparam logic [2:0] REG_TONES_FIRST_FOUR = 3'd1;
  localparam logic [2:0] REG_TONES_LAST_FOUR  = 3'd2;
  localparam logic [2:0] REG_SONG_TEMPO       = 3'd3;
  localparam logic [2:0] REG_BEEP_TEMPO       = 3'd4;

  localparam logic [11:0] TempoReset   = 12'd300;
  localparam logic [15:0] BeepHalfLow  = 16'd440;
  localparam logic [15:0] BeepHalfHigh = 16'd880;
  localparam logic [7:0]  RestName     = 8'd32;
  localparam logic [9:0]  MsToUs       = 10'd1000;
  localparam logic [29:0] ElapsedCap   = 30'h3FFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic start_note;
    logic start_beep;
    logic load;
    logic half_dec;
    logic half_reload;
    logic elapsed_add;
    logic silence_dec;
    logic next_beep;
    logic beep_stop;
  } nts_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic tone_nz;
    logic note_sil_nz;
    logic beep_ok;
    logic half_last;
    logic tone_more;
    logic sil_nz;
    logic sil_last;
    logic in_beep;
    logic beeps_left_nz;
  } nts_stat_t;

endpackage

// ===== sv/note_tone_sequencer.sv =====
// Piezo note and beep tone sequencer, stepped by one-microsecond ticks.
// Command channel (cmd_valid/cmd_stall): cmd selects a tick, a song note or
// rest (note_name, beats) or a beep burst (beep_count, beep_high). A note or
// beep is taken only while idle; otherwise it is answered with accepted = 0.
// Result channel (res_valid/res_stall): one transaction per command
// transaction, carrying speaker level, busy_res and accepted after that item.
// The result is registered on the edge that takes the command.
// A tick, a refused command or a command that leaves the block idle does not
// hold the command channel. A command that leaves the block busy is followed
// by a load state in which the ms lengths are scaled to us by the constant
// multipliers, and cmd_stall is high during it.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the user must
// keep it written only while idle (not enforced here); indexes above four are ignored.
// Reset (rst, synchronous) clears the datapath registers to zero, sets both tempos to
// 300 ms, leaves the block idle and empties the result register.
// While res_stall holds a waiting result, cmd_stall is raised and the result
// stays put.
module note_tone_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  note_name,
  input  logic [7:0]  beats,
  input  logic [7:0]  beep_count,
  input  logic        beep_high,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        speaker,
  output logic        busy_res,
  output logic        accepted
);
  import nts_pkg::*;

  nts_ctl_t  ctl;
  nts_stat_t stat;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  nts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .speaker   (speaker),
    .busy_res  (busy_res),
    .accepted  (accepted),
    .stat      (stat),
    .ctl       (ctl)
  );

  nts_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .note_name  (note_name),
    .beats      (beats),
    .beep_count (beep_count),
    .beep_high  (beep_high),
    .ctl        (ctl),
    .stat       (stat)
  );

endmodule

// ===== sv/nts_datapath.sv =====
// configuration registers, note lookup, timing counters and length arithmetic
module nts_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic [7:0]        note_name,
  input  logic [7:0]        beats,
  input  logic [7:0]        beep_count,
  input  logic              beep_high,
  input  nts_pkg::nts_ctl_t ctl,
  output nts_pkg::nts_stat_t stat
);
  import nts_pkg::*;

  logic [63:0] note_names;
  logic [63:0] tones_first_four;
  logic [63:0] tones_last_four;
  logic [11:0] song_tempo;
  logic [11:0] beep_tempo;

  logic [15:0] half_period;
  logic [15:0] half_count;
  logic [29:0] tone_elapsed;
  logic [29:0] tone_total;
  logic [29:0] silence_left;
  logic [7:0]  beeps_left;
  logic        in_beep;

  // lengths in ms, latched at command start and scaled to us in the load cycle
  logic [19:0] tot_ms;
  logic [10:0] gap_ms;
  logic        sound;

  logic [127:0] tones;
  logic         found;
  logic [15:0]  match_tone;
  logic [15:0]  note_hp;
  logic [15:0]  beep_hp;
  logic [10:0]  beep_half_ms;
  logic         tone_nz;
  logic         beep_ok;
  logic [20:0]  sil_ms;
  logic [30:0]  tone_us;
  logic [30:0]  sil_us;
  logic [30:0]  e_sum;
  logic [29:0]  e_sat;

  assign tones = {tones_last_four, tones_first_four};

  // lowest matching entry wins
  always_comb begin
    found      = 1'b0;
    match_tone = '0;
    for (int i = NoteEntries - 1; i >= 0; i--) begin
      if (note_names[i*8 +: 8] == note_name && note_name != RestName) begin
        found      = 1'b1;
        match_tone = tones[i*16 +: 16];
      end
    end
  end

  assign note_hp      = (found && match_tone != '0) ? match_tone : 16'd1;
  assign beep_hp      = beep_high ? BeepHalfHigh : BeepHalfLow;
  assign beep_half_ms = beep_tempo[11:1];
  assign tone_nz      = beats != '0 && song_tempo != '0;
  assign beep_ok      = beep_count != '0 && beep_half_ms != '0;

  assign sil_ms  = sound ? {10'b0, gap_ms} : {1'b0, tot_ms} + {10'b0, gap_ms};
  assign tone_us = {11'b0, tot_ms} * {21'b0, MsToUs};
  assign sil_us  = {10'b0, sil_ms} * {21'b0, MsToUs};

  assign e_sum = {1'b0, tone_elapsed} + {14'b0, half_period, 1'b0};
  assign e_sat = e_sum[30] ? ElapsedCap : e_sum[29:0];

  assign stat.tone_nz       = found && tone_nz;
  assign stat.note_sil_nz   = song_tempo[11:1] != '0 || (!found && tone_nz);
  assign stat.beep_ok       = beep_ok;
  assign stat.half_last     = half_count <= 16'd1;
  assign stat.tone_more     = e_sat < tone_total;
  assign stat.sil_nz        = silence_left != '0;
  assign stat.sil_last      = silence_left <= 30'd1;
  assign stat.in_beep       = in_beep;
  assign stat.beeps_left_nz = beeps_left != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_names       <= '0;
      tones_first_four <= '0;
      tones_last_four  <= '0;
      song_tempo       <= TempoReset;
      beep_tempo       <= TempoReset;
      half_period      <= '0;
      half_count       <= '0;
      tone_elapsed     <= '0;
      tone_total       <= '0;
      silence_left     <= '0;
      beeps_left       <= '0;
      in_beep          <= 1'b0;
      tot_ms           <= '0;
      gap_ms           <= '0;
      sound            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NOTE_NAMES:       note_names       <= cfg_data;
          REG_TONES_FIRST_FOUR: tones_first_four <= cfg_data;
          REG_TONES_LAST_FOUR:  tones_last_four  <= cfg_data;
          REG_SONG_TEMPO:       song_tempo       <= cfg_data[11:0];
          REG_BEEP_TEMPO:       beep_tempo       <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (ctl.start_note) begin
        half_period  <= note_hp;
        half_count   <= note_hp;
        tone_elapsed <= '0;
        in_beep      <= 1'b0;
        beeps_left   <= '0;
        tot_ms       <= 20'(beats) * 20'(song_tempo);
        gap_ms       <= song_tempo[11:1];
        sound        <= found;
      end

      if (ctl.start_beep) begin
        half_period  <= beep_hp;
        half_count   <= beep_hp;
        tone_elapsed <= '0;
        in_beep      <= beep_ok;
        beeps_left   <= beep_ok ? 8'(beep_count - 8'd1) : 8'd0;
        tot_ms       <= {9'b0, beep_half_ms};
        gap_ms       <= beep_half_ms;
        sound        <= 1'b1;
      end

      // rest or unknown name folds the tone length into the silence
      if (ctl.load) begin
        tone_total   <= sound ? tone_us[29:0] : '0;
        silence_left <= sil_us[29:0];
      end

      if (ctl.half_reload) begin
        half_count <= half_period;
      end else if (ctl.half_dec && half_count != '0) begin
        half_count <= half_count - 16'd1;
      end

      if (ctl.elapsed_add) begin
        tone_elapsed <= e_sat;
      end

      if (ctl.silence_dec && silence_left != '0) begin
        silence_left <= silence_left - 30'd1;
      end

      // during a burst the silence equals the tone length
      if (ctl.next_beep) begin
        beeps_left   <= beeps_left - 8'd1;
        tone_elapsed <= '0;
        silence_left <= tone_total;
        half_count   <= half_period;
      end

      if (ctl.beep_stop) begin
        beeps_left <= '0;
        in_beep    <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/nts_ctrl.sv =====
// sequencing state machine, input handshake and result register
`include "note_tone_sequencer_defines.svh"

module nts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic [1:0]         cmd,
  output logic               cmd_stall,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               speaker,
  output logic               busy_res,
  output logic               accepted,
  input  nts_pkg::nts_stat_t stat,
  output nts_pkg::nts_ctl_t  ctl
);
  import nts_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_LOAD_TONE = 3'd1;
  localparam logic [2:0] ST_LOAD_REST = 3'd2;
  localparam logic [2:0] ST_HIGH      = 3'd3;
  localparam logic [2:0] ST_LOW       = 3'd4;
  localparam logic [2:0] ST_SILENT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       loading;
  logic       take;
  logic       is_tick;
  logic       is_note;
  logic       is_beep;
  logic       acc;
  logic       end_item;

  assign loading   = state == ST_LOAD_TONE || state == ST_LOAD_REST;
  assign cmd_stall = loading || (res_valid && res_stall);
  assign take      = cmd_valid && !cmd_stall;
  assign is_tick   = take && cmd == CMD_TICK;
  assign is_note   = take && cmd == CMD_NOTE;
  assign is_beep   = take && cmd == CMD_BEEP;

  always_comb begin
    ctl        = '0;
    state_next = state;
    acc        = 1'b0;
    end_item   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (is_note) begin
          ctl.start_note = 1'b1;
          acc            = 1'b1;
          if (stat.tone_nz) begin
            state_next = ST_LOAD_TONE;
          end else if (stat.note_sil_nz) begin
            state_next = ST_LOAD_REST;
          end
        end else if (is_beep) begin
          ctl.start_beep = 1'b1;
          acc            = 1'b1;
          if (stat.beep_ok) begin
            state_next = ST_LOAD_TONE;
          end
        end
      end
      ST_LOAD_TONE: begin
        ctl.load   = 1'b1;
        state_next = ST_HIGH;
      end
      ST_LOAD_REST: begin
        ctl.load   = 1'b1;
        state_next = ST_SILENT;
      end
      ST_HIGH: begin
        if (is_tick) begin
          ctl.half_dec = 1'b1;
          if (stat.half_last) begin
            ctl.half_reload = 1'b1;
            state_next      = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        if (is_tick) begin
          ctl.half_dec = 1'b1;
          if (stat.half_last) begin
            ctl.elapsed_add = 1'b1;
            if (stat.tone_more) begin
              ctl.half_reload = 1'b1;
              state_next      = ST_HIGH;
            end else if (stat.sil_nz) begin
              state_next = ST_SILENT;
            end else begin
              end_item = 1'b1;
            end
          end
        end
      end
      ST_SILENT: begin
        if (is_tick) begin
          ctl.silence_dec = 1'b1;
          if (stat.sil_last) begin
            end_item = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // next burst of a beep, or back to idle
    if (end_item) begin
      if (stat.in_beep && stat.beeps_left_nz) begin
        ctl.next_beep = 1'b1;
        state_next    = ST_HIGH;
      end else begin
        ctl.beep_stop = 1'b1;
        state_next    = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      speaker  <= state_next == ST_HIGH || state_next == ST_LOAD_TONE;
      busy_res <= state_next != ST_IDLE;
      accepted <= acc;
    end
  end

  `NTS_ASSERT_NEXT(a_load_to_high, state == ST_LOAD_TONE, state == ST_HIGH, "load did not start tone")
  `NTS_ASSERT_NEXT(a_busy_reject, take && state != ST_IDLE, !accepted, "command taken while busy")
  `NTS_ASSERT_NEXT(a_result_held, take, res_valid, "transaction lost its result")
  `NTS_ASSERT_IMPL(a_beep_idle, state == ST_IDLE, !stat.in_beep, "beep flag left set in idle")

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the piezo note and beep tone sequencer
`timescale 1ns / 1ps

module testbench;
  import nts_pkg::*;

  localparam logic [1:0] CmdSpare  = 2'd3;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned TickChunk = 250;

  typedef enum logic [1:0] {TP_IDLE, TP_HIGH, TP_LOW, TP_QUIET} tone_phase_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] name;
    logic [7:0] beats;
    logic [7:0] count;
    logic       high;
  } tone_cmd_t;

  typedef struct {
    logic speaker;
    logic busy;
    logic taken;
  } tone_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [1:0]  cmd = CMD_TICK;
  logic [7:0]  note_name = '0;
  logic [7:0]  beats = '0;
  logic [7:0]  beep_count = '0;
  logic        beep_high = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        speaker;
  logic        busy_res;
  logic        accepted;

  note_tone_sequencer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .note_name  (note_name),
    .beats      (beats),
    .beep_count (beep_count),
    .beep_high  (beep_high),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .speaker    (speaker),
    .busy_res   (busy_res),
    .accepted   (accepted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [63:0] names_reg;
  logic [63:0] tones_lo_reg;
  logic [63:0] tones_hi_reg;
  logic [11:0] song_tempo_reg;
  logic [11:0] beep_tempo_reg;

  // sequencer state as predicted
  tone_phase_t ph;
  logic [15:0] half_len;
  logic [15:0] half_left;
  logic [29:0] elapsed;
  logic [29:0] tone_len;
  logic [29:0] quiet_left;
  logic [7:0]  bursts_left;
  logic        beeping;

  tone_cmd_t   tone_cmds_q[$];
  tone_res_t   tone_results_q[$];
  tone_cmd_t   offered;
  int unsigned queued_total = 0;
  int unsigned sent_total = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 85;
  logic        hold_arm = 1'b0;
  logic        hold_off = 1'b0;

  function automatic void start_sound();
    elapsed = '0;
    if (half_len == 0) half_len = 16'd1;
    if (tone_len != 0) begin
      ph = TP_HIGH;
      half_left = half_len;
    end else if (quiet_left != 0) begin
      ph = TP_QUIET;
    end else begin
      ph = TP_IDLE;
    end
  endfunction

  function automatic void advance_burst();
    int unsigned half_ms;
    half_ms = 32'(beep_tempo_reg) / 2;
    if (bursts_left == 0 || half_ms == 0) begin
      bursts_left = '0;
      beeping = 1'b0;
      ph = TP_IDLE;
    end else begin
      bursts_left = bursts_left - 8'd1;
      tone_len = 30'(half_ms * MsToUs);
      quiet_left = 30'(half_ms * MsToUs);
      start_sound();
    end
  endfunction

  function automatic void finish_item();
    if (beeping) advance_burst();
    else ph = TP_IDLE;
  endfunction

  function automatic tone_res_t advance_tone(tone_cmd_t c);
    tone_res_t   r;
    int unsigned total;
    int unsigned sum;
    int unsigned bt;
    int unsigned tempo;
    logic [63:0] sel;
    logic        hit;
    r.taken = 1'b0;
    if (c.op == CMD_TICK) begin
      case (ph)
        TP_HIGH: begin
          if (half_left != 0) half_left = half_left - 16'd1;
          if (half_left == 0) begin
            ph = TP_LOW;
            half_left = half_len;
          end
        end
        TP_LOW: begin
          if (half_left != 0) half_left = half_left - 16'd1;
          if (half_left == 0) begin
            sum = elapsed + 2 * half_len;
            elapsed = (sum > ElapsedCap) ? ElapsedCap : sum[29:0];
            if (elapsed < tone_len) begin
              ph = TP_HIGH;
              half_left = half_len;
            end else if (quiet_left != 0) begin
              ph = TP_QUIET;
            end else begin
              finish_item();
            end
          end
        end
        TP_QUIET: begin
          if (quiet_left != 0) quiet_left = quiet_left - 30'd1;
          if (quiet_left == 0) finish_item();
        end
        default: ph = TP_IDLE;
      endcase
    end else if (ph == TP_IDLE && c.op == CMD_NOTE) begin
      r.taken = 1'b1;
      bt = 32'(c.beats);
      tempo = 32'(song_tempo_reg);
      total = bt * tempo * MsToUs;
      beeping = 1'b0;
      bursts_left = '0;
      quiet_left = 30'((tempo / 2) * MsToUs);
      tone_len = '0;
      half_len = 16'd1;
      hit = 1'b0;
      // a space is always a rest, even when a table entry carries it
      if (c.name != RestName) begin
        for (int i = 0; i < NoteEntries; i++) begin
          if (!hit && names_reg[i*8 +: 8] == c.name) begin
            sel = (i < 4) ? tones_lo_reg : tones_hi_reg;
            half_len = sel[(i % 4)*16 +: 16];
            hit = 1'b1;
          end
        end
      end
      if (hit) tone_len = 30'(total);
      else quiet_left = 30'(quiet_left + total);
      start_sound();
    end else if (ph == TP_IDLE && c.op == CMD_BEEP) begin
      r.taken = 1'b1;
      beeping = 1'b1;
      bursts_left = c.count;
      half_len = c.high ? BeepHalfHigh : BeepHalfLow;
      advance_burst();
    end
    r.speaker = (ph == TP_HIGH);
    r.busy = (ph != TP_IDLE);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        tone_results_q.push_back(advance_tone(offered));
        sent_total++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (tone_cmds_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = tone_cmds_q.pop_front();
          cmd_valid  <= 1'b1;
          cmd        <= offered.op;
          note_name  <= offered.name;
          beats      <= offered.beats;
          beep_count <= offered.count;
          beep_high  <= offered.high;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tone_res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (tone_results_q.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          want = tone_results_q.pop_front();
          if (speaker !== want.speaker)
            flag_mismatch($sformatf("result %0d: speaker %b, expected %b",
                                    results_seen, speaker, want.speaker));
          if (busy_res !== want.busy)
            flag_mismatch($sformatf("result %0d: busy_res %b, expected %b",
                                    results_seen, busy_res, want.busy));
          if (accepted !== want.taken)
            flag_mismatch($sformatf("result %0d: accepted %b, expected %b",
                                    results_seen, accepted, want.taken));
          results_seen++;
        end
      end
      res_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up into its command side
  initial begin : hold_off_gen
    wait (hold_arm);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #20_000_000;
    $display("note_tone_sequencer: mismatch");
    $finish;
  end

  task automatic push_cmd(input logic [1:0] op, input logic [7:0] nm, input logic [7:0] bt,
                          input logic [7:0] cnt, input logic hi);
    tone_cmd_t c;
    c.op = op;
    c.name = nm;
    c.beats = bt;
    c.count = cnt;
    c.high = hi;
    tone_cmds_q.push_back(c);
    queued_total++;
  endtask

  // unused fields of a tick carry random values
  task automatic push_tick();
    push_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    while (sent_total != queued_total || tone_results_q.size() != 0) @(posedge clk);
  endtask

  // feed ticks until the sequencer is predicted idle, then let it settle
  task automatic play_out();
    wait_drained();
    while (ph != TP_IDLE) begin
      repeat (TickChunk) push_tick();
      wait_drained();
    end
    repeat (8) @(posedge clk);
  endtask

  // starts just after a rising edge
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NOTE_NAMES:       names_reg = val;
      REG_TONES_FIRST_FOUR: tones_lo_reg = val;
      REG_TONES_LAST_FOUR:  tones_hi_reg = val;
      REG_SONG_TEMPO:       song_tempo_reg = val[11:0];
      REG_BEEP_TEMPO:       beep_tempo_reg = val[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] nms, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [11:0] song, input logic [11:0] bp);
    write_reg(REG_NOTE_NAMES, nms);
    write_reg(REG_TONES_FIRST_FOUR, lo);
    write_reg(REG_TONES_LAST_FOUR, hi);
    write_reg(REG_SONG_TEMPO, {52'($urandom), song});
    write_reg(REG_BEEP_TEMPO, {52'($urandom), bp});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_tones(int unsigned top);
    logic [63:0] w;
    for (int i = 0; i < 4; i++) w[i*16 +: 16] = 16'($urandom_range(0, top));
    return w;
  endfunction

  // mostly well-formed notes and beeps, each followed by a run of ticks
  task automatic random_part(int unsigned budget);
    int unsigned start_n;
    int unsigned roll;
    logic [7:0]  nm;
    logic [7:0]  bt;
    logic [7:0]  cnt;
    start_n = queued_total;
    while (queued_total - start_n < budget) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        roll = $urandom_range(99);
        if (roll < 60) nm = names_reg[8*$urandom_range(0, 7) +: 8];
        else if (roll < 75) nm = RestName;
        else nm = 8'($urandom);
        bt = (song_tempo_reg == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        push_cmd(CMD_NOTE, nm, bt, 8'($urandom), 1'($urandom));
      end else if (roll < 80) begin
        cnt = (beep_tempo_reg / 2 == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        push_cmd(CMD_BEEP, 8'($urandom), 8'($urandom), cnt, 1'($urandom));
      end else if (roll < 90) begin
        push_cmd(CmdSpare, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
      repeat ($urandom_range(0, 400)) push_tick();
    end
  endtask

  initial begin : stimulus
    names_reg = '0;
    tones_lo_reg = '0;
    tones_hi_reg = '0;
    song_tempo_reg = TempoReset;
    beep_tempo_reg = TempoReset;
    ph = TP_IDLE;
    half_len = '0;
    half_left = '0;
    elapsed = '0;
    tone_len = '0;
    quiet_left = '0;
    bursts_left = '0;
    beeping = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // table: c d space e d(dup) nul ff g, tones 3 5 7 0 9 1 ffff 2
    write_reg(RegUnused, '1);
    configure(64'h67FF_0064_6520_6463, 64'h0000_0007_0005_0003,
              64'h0002_FFFF_0001_0009, 12'd1, 12'd2);
    push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    push_cmd(CmdSpare, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_cmd(CMD_NOTE, "c", 8'd1, 8'd0, 1'b0);
    push_cmd(CMD_NOTE, "d", 8'd1, 8'd0, 1'b0);
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd1, 1'b1);
    push_cmd(CmdSpare, 8'h00, 8'h00, 8'h00, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, "d", 8'd1, 8'd0, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, "e", 8'd1, 8'd0, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, RestName, 8'd1, 8'd0, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, "z", 8'd2, 8'd0, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, "g", 8'd0, 8'd0, 1'b0);
    push_cmd(CMD_NOTE, 8'h00, 8'd0, 8'd0, 1'b0);
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd2, 1'b0);
    play_out();
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd1, 1'b1);
    play_out();

    // zero song tempo and a beep tempo of one: every command goes straight back to idle
    configure(names_reg, tones_lo_reg, tones_hi_reg, 12'd0, 12'd1);
    push_cmd(CMD_NOTE, "c", 8'hFF, 8'd0, 1'b0);
    push_cmd(CMD_NOTE, RestName, 8'hFF, 8'd0, 1'b0);
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'hFF, 1'b1);
    play_out();

    // odd tempo, a zero-length note that is only a gap, then a sounded note
    configure(names_reg, tones_lo_reg, tones_hi_reg, 12'd3, 12'd2);
    push_cmd(CMD_NOTE, "g", 8'd0, 8'd0, 1'b0);
    play_out();
    push_cmd(CMD_NOTE, "c", 8'd1, 8'd0, 1'b0);
    play_out();

    configure({$urandom, $urandom}, random_tones(15), random_tones(15), 12'd1, 12'd2);
    random_part(600);
    play_out();

    send_idle_pct <= 85;
    recv_idle_pct <= 38;
    configure({$urandom, $urandom}, random_tones(300), random_tones(300), 12'd2, 12'd3);
    random_part(600);
    play_out();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    configure({$urandom, $urandom}, random_tones(40), random_tones(40), 12'd1, 12'd0);
    hold_arm = 1'b1;
    random_part(600);
    play_out();

    // largest settings: one very long note, later commands refused
    configure('1, '1, '1, 12'hFFF, 12'hFFF);
    push_cmd(CMD_NOTE, 8'hFF, 8'hFF, 8'd0, 1'b0);
    repeat (10) push_tick();
    push_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd3, 1'b1);
    push_cmd(CMD_NOTE, 8'hFF, 8'd1, 8'd0, 1'b0);
    repeat (10) push_tick();
    wait_drained();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("note_tone_sequencer: match");
    end else begin
      $display("note_tone_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/nts_pkg.sv
sv/nts_datapath.sv
sv/nts_ctrl.sv
sv/note_tone_sequencer.sv
sim/testbench.sv
